[design/miller_index_orbit_generator_top_defines.svh]
// Assertion macros for the checker file of the orbit generator.
// No dependencies; include by bare file name.
`ifndef MILLER_INDEX_ORBIT_GENERATOR_TOP_DEFINES_SVH
`define MILLER_INDEX_ORBIT_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MIO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define MIO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/mio_pkg.sv]
// Shared constants, types and controller/datapath interface structs
// for the Miller index orbit generator. No dependencies.
package mio_pkg;

  localparam int MAX_INDEX  = 255;
  localparam int COEF_W     = 16;
  localparam int IDX_W      = $clog2(MAX_INDEX + 1);
  localparam int VEC_W      = IDX_W + 1;
  localparam int OUT_IDX_W  = 9;
  localparam int NORM_W     = 16;
  localparam int REG_W      = 48;
  localparam int NUM_REGS   = 6;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int ROW_W      = (3 * COEF_W > REG_W) ? 3 * COEF_W : REG_W;
  localparam int P_W        = COEF_W + VEC_W + 2;
  localparam int S_W        = 2 * P_W + 2;
  localparam int ROOT_STEPS = (S_W + 1) / 2;
  localparam int R_W        = ROOT_STEPS;
  localparam int FRAC_W     = 15;
  localparam int Q_W        = 16;
  localparam int NUM_W      = P_W + Q_W;
  localparam int DIV_STEPS  = Q_W;
  localparam int CNT_MAX    = (ROOT_STEPS > DIV_STEPS + 1) ? ROOT_STEPS : DIV_STEPS + 1;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);
  localparam int NUM_POS    = 6;
  localparam int POS_W      = $clog2(NUM_POS);
  localparam int ORB_W      = 6;

  localparam logic [REG_W-1:0] ROW0_RST = 48'd4096;
  localparam logic [REG_W-1:0] ROW1_RST = 48'd268435456;
  localparam logic [REG_W-1:0] ROW2_RST = 48'd17592186044416;

  typedef struct packed {
    logic       adv;
    logic       gcd_load2;
    logic       gcd_step;
    logic       scan_clr;
    logic       scan_next;
    logic       vec_load;
    logic       prod;
    logic       sq;
    logic       root_init;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       emit_done;
    logic [1:0] part;
    logic       side;
  } mio_cmd_t;

  typedef struct packed {
    logic over_max;
    logic gcd_zero;
    logic gcd_one;
    logic combo_ok;
    logic last;
  } mio_stat_t;

endpackage

[design/mio_ctrl.sv]
// Sequencer for the orbit generator: steps gcd, orbit scan, normalization, emit.
// Depends on mio_pkg.
module mio_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_step,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  mio_pkg::mio_stat_t stat,
  output mio_pkg::mio_cmd_t  cmd
);
  import mio_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_GCD1 = 9'b000000010,
    S_GCD2 = 9'b000000100,
    S_SCAN = 9'b000001000,
    S_PROD = 9'b000010000,
    S_SQ   = 9'b000100000,
    S_ROOT = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       part_r, part_nxt;
  logic             side_r, side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      part_r  <= '0;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      part_r  <= part_nxt;
      side_r  <= side_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    part_nxt  = part_r;
    side_nxt  = side_r;
    cmd       = '0;
    cmd.part  = part_r;
    cmd.side  = side_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_step && !stat.over_max) begin
          cmd.adv   = 1'b1;
          state_nxt = S_GCD1;
        end
      end
      S_GCD1: begin
        if (stat.gcd_zero) begin
          cmd.gcd_load2 = 1'b1;
          state_nxt     = S_GCD2;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_GCD2: begin
        if (stat.gcd_zero) begin
          if (stat.gcd_one) begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat.combo_ok) begin
          cmd.vec_load = 1'b1;
          part_nxt     = '0;
          side_nxt     = 1'b0;
          state_nxt    = S_PROD;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_PROD: begin
        cmd.prod = 1'b1;
        if (part_r == 2'd2) begin
          part_nxt  = '0;
          state_nxt = S_SQ;
        end else begin
          part_nxt = part_r + 2'd1;
        end
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        if (part_r == 2'd2) begin
          part_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_ROOT;
        end else begin
          part_nxt = part_r + 2'd1;
        end
      end
      S_ROOT: begin
        if (cnt_r == '0) cmd.root_init = 1'b1;
        else             cmd.root_step = 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DIV: begin
        if (cnt_r == '0)                          cmd.div_init  = 1'b1;
        else if (cnt_r == CNT_W'(DIV_STEPS + 1)) cmd.div_store = 1'b1;
        else                                      cmd.div_step  = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS + 1)) begin
          cnt_nxt = '0;
          if (part_r == 2'd2) begin
            part_nxt = '0;
            if (side_r) begin
              state_nxt = S_EMIT;
            end else begin
              side_nxt  = 1'b1;
              state_nxt = S_PROD;
            end
          end else begin
            part_nxt = part_r + 2'd1;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit_done = 1'b1;
          if (stat.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[design/mio_dp.sv]
// Datapath: index triple, gcd, orbit scan, matrix products, root and divider.
// Depends on mio_pkg.
module mio_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [mio_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [mio_pkg::REG_W-1:0]              cfg_wdata,
  input  mio_pkg::mio_cmd_t                      cmd,
  output mio_pkg::mio_stat_t                     stat,
  output logic signed [mio_pkg::OUT_IDX_W-1:0]   out_idx_h,
  output logic signed [mio_pkg::OUT_IDX_W-1:0]   out_idx_k,
  output logic signed [mio_pkg::OUT_IDX_W-1:0]   out_idx_l,
  output logic signed [mio_pkg::NORM_W-1:0]      out_real_x,
  output logic signed [mio_pkg::NORM_W-1:0]      out_real_y,
  output logic signed [mio_pkg::NORM_W-1:0]      out_real_z,
  output logic signed [mio_pkg::NORM_W-1:0]      out_recip_x,
  output logic signed [mio_pkg::NORM_W-1:0]      out_recip_y,
  output logic signed [mio_pkg::NORM_W-1:0]      out_recip_z,
  output logic                                   out_last
);
  import mio_pkg::*;

  function automatic logic signed [COEF_W-1:0] coef_of(input logic [REG_W-1:0] row,
                                                      input logic [1:0] j);
    logic [ROW_W-1:0] ext;
    ext = ROW_W'(row);
    return ext[j * COEF_W +: COEF_W];
  endfunction

  // configuration and index state
  logic [REG_W-1:0] cfg_r [NUM_REGS];
  logic [IDX_W-1:0] h_r, k_r, l_r;
  logic [IDX_W-1:0] ga_r, gb_r;
  logic [POS_W-1:0] ci_r, cj_r, cm_r;
  logic [ORB_W-1:0] emit_cnt_r;

  // payload
  logic signed [VEC_W-1:0]  vec_r [3];
  logic signed [P_W-1:0]    p_r [3];
  logic [S_W-1:0]           s_r, rem_r, res_r, bit_r;
  logic [R_W-1:0]           drem_r;
  logic [Q_W-1:0]           dlow_r, q_r;
  logic signed [NORM_W-1:0] nrm_r [2][3];

  // next triple
  logic [IDX_W:0] nh_w, nk_w, nl_w;
  always_comb begin
    nh_w = {1'b0, h_r};
    nk_w = {1'b0, k_r};
    nl_w = {1'b0, l_r} + 1'b1;
    if (nl_w > nk_w) begin
      nk_w = nk_w + 1'b1;
      nl_w = '0;
    end
    if (nk_w > nh_w) begin
      nh_w = nh_w + 1'b1;
      nk_w = '0;
    end
  end

  // candidate values in ascending order: -h -k -l l k h
  logic [IDX_W-1:0]        mg_w  [NUM_POS];
  logic signed [VEC_W-1:0] val_w [NUM_POS];
  logic                    skip_w [NUM_POS];
  always_comb begin
    mg_w[0] = h_r; mg_w[1] = k_r; mg_w[2] = l_r;
    mg_w[3] = l_r; mg_w[4] = k_r; mg_w[5] = h_r;
    for (int p = 0; p < NUM_POS; p++) begin
      if (p < 3) val_w[p] = -$signed({1'b0, mg_w[p]});
      else       val_w[p] = $signed({1'b0, mg_w[p]});
    end
    skip_w[0] = 1'b0;
    for (int p = 1; p < NUM_POS; p++) skip_w[p] = (val_w[p] == val_w[p-1]);
  end

  logic [IDX_W-1:0] sa_w, sb_w, sc_w, st_w;
  always_comb begin
    sa_w = mg_w[ci_r];
    sb_w = mg_w[cj_r];
    sc_w = mg_w[cm_r];
    st_w = '0;
    if (sa_w < sb_w) begin st_w = sa_w; sa_w = sb_w; sb_w = st_w; end
    if (sb_w < sc_w) begin st_w = sb_w; sb_w = sc_w; sc_w = st_w; end
    if (sa_w < sb_w) begin st_w = sa_w; sa_w = sb_w; sb_w = st_w; end
  end

  // orbit size: distinct orderings times sign choices of nonzero parts
  logic [ORB_W-1:0] perms_w, n_w;
  logic [1:0]       nz_w;
  always_comb begin
    if (h_r != k_r && k_r != l_r)      perms_w = ORB_W'(6);
    else if (h_r == k_r && k_r == l_r) perms_w = ORB_W'(1);
    else                               perms_w = ORB_W'(3);
    nz_w = 2'(h_r != '0) + 2'(k_r != '0) + 2'(l_r != '0);
    n_w  = perms_w << nz_w;
  end

  // row product
  logic [CFG_IDX_W-1:0]            rsel_w;
  logic signed [COEF_W+VEC_W-1:0]  pr_w [3];
  logic signed [P_W-1:0]           psum_w;
  always_comb begin
    rsel_w = cmd.side ? CFG_IDX_W'(cmd.part) + CFG_IDX_W'(3) : CFG_IDX_W'(cmd.part);
    for (int j = 0; j < 3; j++) pr_w[j] = coef_of(cfg_r[rsel_w], 2'(j)) * vec_r[j];
    psum_w = P_W'(pr_w[0]) + P_W'(pr_w[1]) + P_W'(pr_w[2]);
  end

  // magnitudes, halved when any reaches 2^31
  logic [P_W-1:0] mag_w [3];
  logic [P_W-1:0] magh_w [3];
  logic           neg_w [3];
  logic           big_w;
  always_comb begin
    big_w = 1'b0;
    for (int i = 0; i < 3; i++) begin
      neg_w[i] = p_r[i][P_W-1];
      mag_w[i] = neg_w[i] ? -p_r[i] : p_r[i];
      if (64'(mag_w[i]) >= 64'h8000_0000) big_w = 1'b1;
    end
    for (int i = 0; i < 3; i++) magh_w[i] = big_w ? (mag_w[i] >> 1) : mag_w[i];
  end

  logic [2*P_W-1:0] sq_w;
  assign sq_w = magh_w[cmd.part] * magh_w[cmd.part];

  logic [S_W-1:0] trial_w;
  logic [R_W-1:0] r_w;
  assign trial_w = res_r + bit_r;
  assign r_w     = res_r[R_W-1:0];

  logic [NUM_W-1:0] num_w;
  logic [R_W:0]     dtrial_w;
  logic [Q_W-1:0]   qc_w;
  logic signed [NORM_W-1:0] nval_w;
  always_comb begin
    num_w    = (NUM_W'(magh_w[cmd.part]) << FRAC_W) + NUM_W'(r_w >> 1);
    dtrial_w = {drem_r, dlow_r[Q_W-1]};
    qc_w     = (q_r > Q_W'(32767)) ? Q_W'(32767) : q_r;
    if (s_r == '0)              nval_w = '0;
    else if (neg_w[cmd.part])   nval_w = -$signed(qc_w);
    else                        nval_w = $signed(qc_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= ROW0_RST; cfg_r[1] <= ROW1_RST; cfg_r[2] <= ROW2_RST;
      cfg_r[3] <= ROW0_RST; cfg_r[4] <= ROW1_RST; cfg_r[5] <= ROW2_RST;
      h_r <= '0; k_r <= '0; l_r <= '0;
      ga_r <= '0; gb_r <= '0;
      ci_r <= '0; cj_r <= '0; cm_r <= '0;
      emit_cnt_r <= '0;
    end else begin
      if (cfg_we && cfg_idx < CFG_IDX_W'(NUM_REGS)) cfg_r[cfg_idx] <= cfg_wdata;
      if (cmd.adv) begin
        h_r  <= nh_w[IDX_W-1:0];
        k_r  <= nk_w[IDX_W-1:0];
        l_r  <= nl_w[IDX_W-1:0];
        ga_r <= nk_w[IDX_W-1:0];
        gb_r <= nl_w[IDX_W-1:0];
      end else if (cmd.gcd_load2) begin
        ga_r <= h_r;
        gb_r <= ga_r;
      end else if (cmd.gcd_step) begin
        if (ga_r >= gb_r) begin
          ga_r <= ga_r - gb_r;
        end else begin
          ga_r <= gb_r;
          gb_r <= ga_r;
        end
      end
      if (cmd.scan_clr) begin
        ci_r <= '0; cj_r <= '0; cm_r <= '0;
        emit_cnt_r <= '0;
      end else if (cmd.scan_next) begin
        if (cm_r == POS_W'(NUM_POS - 1)) begin
          cm_r <= '0;
          if (cj_r == POS_W'(NUM_POS - 1)) begin
            cj_r <= '0;
            ci_r <= ci_r + POS_W'(1);
          end else begin
            cj_r <= cj_r + POS_W'(1);
          end
        end else begin
          cm_r <= cm_r + POS_W'(1);
        end
      end
      if (cmd.emit_done) emit_cnt_r <= emit_cnt_r + ORB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vec_load) begin
      vec_r[0] <= val_w[ci_r];
      vec_r[1] <= val_w[cj_r];
      vec_r[2] <= val_w[cm_r];
    end
    if (cmd.prod) p_r[cmd.part] <= psum_w;
    if (cmd.sq) s_r <= ((cmd.part == 2'd0) ? '0 : s_r) + S_W'(sq_w);
    if (cmd.root_init) begin
      rem_r <= s_r;
      res_r <= '0;
      bit_r <= S_W'(1) << (2 * (ROOT_STEPS - 1));
    end else if (cmd.root_step) begin
      if (rem_r >= trial_w) begin
        rem_r <= rem_r - trial_w;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_init) begin
      drem_r <= R_W'(num_w[NUM_W-1:Q_W]);
      dlow_r <= num_w[Q_W-1:0];
      q_r    <= '0;
    end else if (cmd.div_step) begin
      if (dtrial_w >= {1'b0, r_w}) begin
        drem_r <= R_W'(dtrial_w - {1'b0, r_w});
        q_r    <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        drem_r <= R_W'(dtrial_w);
        q_r    <= {q_r[Q_W-2:0], 1'b0};
      end
      dlow_r <= dlow_r << 1;
    end
    if (cmd.div_store) nrm_r[cmd.side][cmd.part] <= nval_w;
  end

  always_comb begin
    stat.over_max = (nh_w > (IDX_W+1)'(MAX_INDEX));
    stat.gcd_zero = (gb_r == '0);
    stat.gcd_one  = (ga_r == IDX_W'(1));
    stat.combo_ok = !skip_w[ci_r] && !skip_w[cj_r] && !skip_w[cm_r] &&
                    sa_w == h_r && sb_w == k_r && sc_w == l_r;
    stat.last     = (emit_cnt_r + ORB_W'(1) == n_w);
  end

  assign out_idx_h   = OUT_IDX_W'(vec_r[0]);
  assign out_idx_k   = OUT_IDX_W'(vec_r[1]);
  assign out_idx_l   = OUT_IDX_W'(vec_r[2]);
  assign out_real_x  = nrm_r[0][0];
  assign out_real_y  = nrm_r[0][1];
  assign out_real_z  = nrm_r[0][2];
  assign out_recip_x = nrm_r[1][0];
  assign out_recip_y = nrm_r[1][1];
  assign out_recip_z = nrm_r[1][2];
  assign out_last    = stat.last;

endmodule

[design/miller_index_orbit_generator_top.sv]
// Miller index orbit generator, top level. Depends on mio_pkg, mio_ctrl, mio_dp.
// One item at a time; in_stall stays high from an advancing step until its last result is taken,
// or until the gcd rejects the triple. Per step: gcd by subtraction, then a scan over candidate
// vectors, then for each emitted vector two products (real and reciprocal), each through
// multiply, square, root and divide phases, and then the output handshake.
// Reset (rst_n low, synchronous): triple to 0, matrices to 4096 times identity, sequencer to idle.
module miller_index_orbit_generator_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // step items
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_step,
  // orbit results
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mio_pkg::OUT_IDX_W-1:0]   out_idx_h,
  output logic signed [mio_pkg::OUT_IDX_W-1:0]   out_idx_k,
  output logic signed [mio_pkg::OUT_IDX_W-1:0]   out_idx_l,
  output logic signed [mio_pkg::NORM_W-1:0]      out_real_x,
  output logic signed [mio_pkg::NORM_W-1:0]      out_real_y,
  output logic signed [mio_pkg::NORM_W-1:0]      out_real_z,
  output logic signed [mio_pkg::NORM_W-1:0]      out_recip_x,
  output logic signed [mio_pkg::NORM_W-1:0]      out_recip_y,
  output logic signed [mio_pkg::NORM_W-1:0]      out_recip_z,
  output logic                                   out_last,
  // matrix rows: real 0..2, reciprocal 3..5
  input  logic                                   cfg_we,
  input  logic [mio_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [mio_pkg::REG_W-1:0]              cfg_wdata
);
  import mio_pkg::*;

  mio_cmd_t  cmd;
  mio_stat_t stat;

  // Sequencer: idle -> gcd -> scan -> (product, squares, root, divide) x2 -> emit.
  // The scan walks the ordered picks from -h -k -l l k h, so vectors come out in
  // ascending order; repeated values are skipped, which removes duplicates.
  mio_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_step   (in_step),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath holds the triple, gcd registers, scan position, the row-product and
  // square multipliers, the bitwise square root and the restoring divider.
  // Output fields come from its registers (out_last from a compare on them), stable while stalled.
  mio_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_idx_h   (out_idx_h),
    .out_idx_k   (out_idx_k),
    .out_idx_l   (out_idx_l),
    .out_real_x  (out_real_x),
    .out_real_y  (out_real_y),
    .out_real_z  (out_real_z),
    .out_recip_x (out_recip_x),
    .out_recip_y (out_recip_y),
    .out_recip_z (out_recip_z),
    .out_last    (out_last)
  );

endmodule

[design/mio_checker.sv]
// Port-level checks for the orbit generator, bound to the top level.
// Depends on mio_pkg and miller_index_orbit_generator_top_defines.svh.
`include "miller_index_orbit_generator_top_defines.svh"
module mio_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 in_step,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [mio_pkg::OUT_IDX_W-1:0] out_idx_h,
  input logic signed [mio_pkg::OUT_IDX_W-1:0] out_idx_k,
  input logic signed [mio_pkg::OUT_IDX_W-1:0] out_idx_l,
  input logic signed [mio_pkg::NORM_W-1:0]    out_real_x,
  input logic signed [mio_pkg::NORM_W-1:0]    out_recip_x,
  input logic                                 out_last
);
  // busy while a result is pending
  `MIO_ASSERT_IMP(a_busy_on_result, out_valid, in_stall)
  // stalled result holds
  `MIO_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_idx_h) && $stable(out_idx_k) && $stable(out_idx_l) && $stable(out_real_x) && $stable(out_recip_x) && $stable(out_last))
  // idle step leaves block idle
  `MIO_ASSERT_NXT(a_noop_step, in_valid && !in_stall && !in_step, !in_stall && !out_valid)
  // final vector taken returns to idle
  `MIO_ASSERT_NXT(a_last_idle, out_valid && !out_stall && out_last, !out_valid && !in_stall)
endmodule

bind miller_index_orbit_generator_top mio_checker u_chk (.*);

[test/miller_index_orbit_generator_top_tb.sv]
// Self-checking bench for miller_index_orbit_generator_top: drives step items, predicts each
// orbit with its normalized real and reciprocal normals, and checks every result in order.
// Depends on mio_pkg and the design sources only.
module miller_index_orbit_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mio_pkg::*;

  // one expected orbit vector
  typedef struct {
    logic signed [OUT_IDX_W-1:0] h, k, l;
    logic signed [NORM_W-1:0]    rl_x, rl_y, rl_z;
    logic signed [NORM_W-1:0]    rc_x, rc_y, rc_z;
    logic                        last;
  } orbit_vec_t;

  // directed stimulus row; chk marks rows whose first vector is typed in
  typedef struct {
    logic                        step;
    bit                          chk;
    logic signed [OUT_IDX_W-1:0] h, k, l;
    logic signed [NORM_W-1:0]    rl_x;
  } step_row_t;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 800;   // gcd + scan of a silent step

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_step = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [OUT_IDX_W-1:0] out_idx_h, out_idx_k, out_idx_l;
  logic signed [NORM_W-1:0] out_real_x, out_real_y, out_real_z;
  logic signed [NORM_W-1:0] out_recip_x, out_recip_y, out_recip_z;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  miller_index_orbit_generator_top dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [REG_W-1:0] mtx_rows [NUM_REGS];
  int unsigned tri_h, tri_k, tri_l;
  orbit_vec_t orbit_q[$];
  int err_cnt = 0;
  bit calm = 1'b0;          // no idling on either side while set
  int hold_req = 0;         // bumped to ask the receiver for a long hold

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // normalized M*v for the matrix whose rows start at register base
  function automatic void unit_normal(int base, int v[3], output logic signed [NORM_W-1:0] n[3]);
    longint unsigned mag[3];
    bit neg[3];
    bit big = 0;
    longint unsigned s = 0, r, q;
    longint p;
    for (int i = 0; i < 3; i++) begin
      p = 0;
      for (int j = 0; j < 3; j++)
        p += longint'($signed(mtx_rows[base+i][j*COEF_W +: COEF_W])) * v[j];
      neg[i] = p < 0;
      mag[i] = neg[i] ? -p : p;
      if (mag[i] >= (64'd1 << 31)) big = 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (big) mag[i] >>= 1;
      s += mag[i] * mag[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (s == 0) begin
        n[i] = '0;
      end else begin
        r = root_floor(s);
        q = ((mag[i] << 15) + (r >> 1)) / r;
        if (q > 32767) q = 32767;
        n[i] = neg[i] ? -q[15:0] : q[15:0];
      end
    end
  endfunction

  function automatic bit vec_below(int a[3], int b[3]);
    for (int i = 0; i < 3; i++) begin
      if (a[i] < b[i]) return 1;
      if (a[i] > b[i]) return 0;
    end
    return 0;
  endfunction

  function automatic int unsigned gcd2(int unsigned a, int unsigned b);
    int unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // advance the triple and queue its orbit
  function automatic void predict_orbit(logic step);
    int perm[6][3] = '{'{0,1,2}, '{0,2,1}, '{1,0,2}, '{1,2,0}, '{2,0,1}, '{2,1,0}};
    int unsigned nh = tri_h, nk = tri_k, nl = tri_l;
    int base[3];
    int orb[48][3];
    int c[3];
    int cnt = 0, pos;
    bit dup;
    orbit_vec_t e;
    logic signed [NORM_W-1:0] nr[3], nc[3];
    if (!step) return;
    nl++;
    if (nl > nk) begin nk++; nl = 0; end
    if (nk > nh) begin nh++; nk = 0; end
    if (nh > MAX_INDEX) return;
    tri_h = nh; tri_k = nk; tri_l = nl;
    if (gcd2(nh, gcd2(nk, nl)) != 1) return;
    base = '{nh, nk, nl};
    for (int p = 0; p < 6; p++) begin
      for (int sg = 0; sg < 8; sg++) begin
        for (int i = 0; i < 3; i++) c[i] = sg[i] ? -base[perm[p][i]] : base[perm[p][i]];
        dup = 0;
        for (int i = 0; i < cnt; i++) if (orb[i] == c) dup = 1;
        if (!dup) begin
          pos = cnt;
          while (pos > 0 && vec_below(c, orb[pos-1])) begin
            orb[pos] = orb[pos-1];
            pos--;
          end
          orb[pos] = c;
          cnt++;
        end
      end
    end
    for (int i = 0; i < cnt; i++) begin
      unit_normal(0, orb[i], nr);
      unit_normal(3, orb[i], nc);
      e.h = OUT_IDX_W'(orb[i][0]);
      e.k = OUT_IDX_W'(orb[i][1]);
      e.l = OUT_IDX_W'(orb[i][2]);
      e.rl_x = nr[0]; e.rl_y = nr[1]; e.rl_z = nr[2];
      e.rc_x = nc[0]; e.rc_y = nc[1]; e.rc_z = nc[2];
      e.last = (i == cnt - 1);
      orbit_q.push_back(e);
    end
  endfunction

  // Receiver: checks each taken result against the oldest expected vector,
  // then picks the next stall value. A hold request forces a long stall.
  int hold_cnt = 0;
  int hold_done = 0;
  always @(posedge clk) begin
    orbit_vec_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (orbit_q.size() == 0) begin
          $display("MISMATCH unexpected result %0d %0d %0d at %0t",
                   out_idx_h, out_idx_k, out_idx_l, $realtime);
          err_cnt++;
        end else begin
          e = orbit_q.pop_front();
          if (out_idx_h !== e.h) flag_mismatch("idx_h", out_idx_h, e.h);
          if (out_idx_k !== e.k) flag_mismatch("idx_k", out_idx_k, e.k);
          if (out_idx_l !== e.l) flag_mismatch("idx_l", out_idx_l, e.l);
          if (out_real_x !== e.rl_x) flag_mismatch("real_x", out_real_x, e.rl_x);
          if (out_real_y !== e.rl_y) flag_mismatch("real_y", out_real_y, e.rl_y);
          if (out_real_z !== e.rl_z) flag_mismatch("real_z", out_real_z, e.rl_z);
          if (out_recip_x !== e.rc_x) flag_mismatch("recip_x", out_recip_x, e.rc_x);
          if (out_recip_y !== e.rc_y) flag_mismatch("recip_y", out_recip_y, e.rc_y);
          if (out_recip_z !== e.rc_z) flag_mismatch("recip_z", out_recip_z, e.rc_z);
          if (out_last !== e.last) flag_mismatch("last", out_last, e.last);
        end
      end
      if (hold_req != hold_done) begin
        hold_done <= hold_req;
        hold_cnt <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 17);
      end
    end
  end

  // offer one item, hold it until taken, then maybe leave a gap
  task automatic send_step(logic s);
    in_valid <= 1'b1;
    in_step <= s;
    do @(posedge clk); while (in_stall);
    predict_orbit(s);
    if (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // sender pause: everything back, then time for a silent step to finish
  task automatic drain_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (orbit_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_matrices(logic [REG_W-1:0] vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= i[CFG_IDX_W-1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
      mtx_rows[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [REG_W-1:0] pack_row(logic [COEF_W-1:0] a, b, c);
    return {c, b, a};
  endfunction

  // Directed part at the reset matrices: the first step reaches (1,0,0), whose
  // lowest vector (-1,0,0) saturates to -32767 on 4096 times identity. The walk
  // also crosses common-divisor triples (2,0,0), (2,2,0), (2,2,2) that emit
  // nothing, and idle steps.
  step_row_t dir_rows[] = '{
    '{1'b0, 0, 0, 0, 0, 0},
    '{1'b1, 1, -9'sd1, 9'sd0, 9'sd0, -16'sd32767},
    '{1'b0, 0, 0, 0, 0, 0},
    '{1'b1, 0, 0, 0, 0, 0},
    '{1'b1, 0, 0, 0, 0, 0},
    '{1'b1, 0, 0, 0, 0, 0},
    '{1'b0, 0, 0, 0, 0, 0},
    '{1'b1, 0, 0, 0, 0, 0},
    '{1'b1, 0, 0, 0, 0, 0},
    '{1'b1, 0, 0, 0, 0, 0},
    '{1'b1, 0, 0, 0, 0, 0},
    '{1'b1, 0, 0, 0, 0, 0},
    '{1'b0, 0, 0, 0, 0, 0},
    '{1'b1, 0, 0, 0, 0, 0}
  };

  initial begin
    logic [REG_W-1:0] vals [NUM_REGS];
    int q_before;
    int steps_done = 0;
    mtx_rows = '{ROW0_RST, ROW1_RST, ROW2_RST, ROW0_RST, ROW1_RST, ROW2_RST};
    tri_h = 0; tri_k = 0; tri_l = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      q_before = orbit_q.size();
      // long receiver hold while the sender keeps offering items
      if (r == 5) hold_req++;
      send_step(dir_rows[r].step);
      if (dir_rows[r].chk) begin
        if (orbit_q.size() == q_before) begin
          $display("MISMATCH directed row %0d produced no orbit", r);
          err_cnt++;
        end else begin
          if (orbit_q[q_before].h !== dir_rows[r].h)
            flag_mismatch("typed idx_h", orbit_q[q_before].h, dir_rows[r].h);
          if (orbit_q[q_before].k !== dir_rows[r].k)
            flag_mismatch("typed idx_k", orbit_q[q_before].k, dir_rows[r].k);
          if (orbit_q[q_before].l !== dir_rows[r].l)
            flag_mismatch("typed idx_l", orbit_q[q_before].l, dir_rows[r].l);
          if (orbit_q[q_before].rl_x !== dir_rows[r].rl_x)
            flag_mismatch("typed real_x", orbit_q[q_before].rl_x, dir_rows[r].rl_x);
        end
      end
    end

    // Random phases, each behind its own matrix setting: zero (zero product),
    // all ones (every coefficient -1), largest positive, most negative, and
    // random rows. Phase 2 runs with no idling at all.
    for (int ph = 0; ph < 6; ph++) begin
      drain_idle();
      for (int i = 0; i < NUM_REGS; i++) begin
        case (ph)
          0: vals[i] = '0;
          1: vals[i] = '1;
          2: vals[i] = pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF);
          3: vals[i] = pack_row(16'h8000, 16'h8000, 16'h8000);
          default: vals[i] = pack_row(COEF_W'($urandom), COEF_W'($urandom),
                                      COEF_W'($urandom));
        endcase
      end
      load_matrices(vals);
      calm = (ph == 2);
      for (int n = 0; n < 16; n++) begin
        if ($urandom_range(99) < 15) send_step(1'b0);
        send_step(1'b1);
        steps_done++;
        if (ph == 4 && n == 3) hold_req++;
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (orbit_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && orbit_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/mio_pkg.sv
design/mio_ctrl.sv
design/mio_dp.sv
design/miller_index_orbit_generator_top.sv
design/mio_checker.sv
test/miller_index_orbit_generator_top_tb.sv
